// File: sv/mrpg_pkg.sv
// mrpg_pkg: shared types, constants and the sine table of the Maurer rose point generator.
// Used by every module of the block; depends on nothing.
// The sine table is built at elaboration from a fixed-point Taylor series.
package mrpg_pkg;

	// Curve and output format
	localparam int unsigned POINT_COUNT   = 361;
	localparam int unsigned OUT_FRAC_BITS = 8;
	localparam int unsigned QUEUE_DEPTH   = 8;

	localparam logic [8:0] IDX_LAST = 9'(POINT_COUNT - 1);

	// Angle constants in degrees
	localparam int unsigned ANGLE_MOD = 360;
	localparam logic [8:0] DEG_90  = 9'd90;
	localparam logic [8:0] DEG_180 = 9'd180;
	localparam logic [8:0] DEG_270 = 9'd270;
	localparam logic [8:0] DEG_360 = 9'd360;

	// Configuration register indexes and reset values
	localparam logic [1:0] REG_HARMONIC = 2'd0;
	localparam logic [1:0] REG_STEP     = 2'd1;
	localparam logic [1:0] REG_SCALE    = 2'd2;

	localparam logic [6:0] HARMONIC_RST = 7'd6;
	localparam logic [8:0] STEP_RST     = 9'd71;
	localparam logic [8:0] SCALE_RST    = 9'd200;

	// Output rounding and saturation (products are Q2.30 times scale)
	localparam int unsigned RND_SHIFT   = 30 - OUT_FRAC_BITS;
	localparam logic [39:0] ROUND_ADD   = 40'(1) << (RND_SHIFT - 1);
	localparam logic [39:0] OUT_POS_LIM = 40'd131071;
	localparam logic [39:0] OUT_NEG_LIM = 40'd131072;

	// One angle moving from the front through the queue to the back
	typedef struct packed {
		logic       valid;
		logic [8:0] angle;
	} angle_item_t;

	// Quarter-wave sine table, Q1.15, entries 0..90 degrees
	typedef logic [14:0] sine_rom_t [0:90];

	localparam logic [63:0] RAD_PER_DEG_Q30 = 64'd18740330;
	localparam int unsigned TAYLOR_DIV [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] q;
		for (int a = 0; a <= 90; a++) begin
			x    = 64'(a) * RAD_PER_DEG_Q30;
			x2   = (x * x) >> 30;
			term = x;
			sum  = x;
			for (int n = 1; n <= 8; n++) begin
				term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n]);
				if ((n % 2) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			q = (sum + 64'd16384) >> 15;
			if (q > 64'd32767) begin
				q = 64'd32767;
			end
			rom[a] = q[14:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// Sine of an angle in 0..359 degrees, Q1.15, by quadrant folding
	function automatic logic signed [15:0] sine_q15(input logic [8:0] deg);
		logic [8:0]  a;
		logic        neg;
		logic [15:0] mag;
		if (deg <= DEG_90) begin
			a   = deg;
			neg = 1'b0;
		end else if (deg <= DEG_180) begin
			a   = DEG_180 - deg;
			neg = 1'b0;
		end else if (deg <= DEG_270) begin
			a   = deg - DEG_180;
			neg = 1'b1;
		end else begin
			a   = DEG_360 - deg;
			neg = 1'b1;
		end
		mag = {1'b0, SINE_ROM[a[6:0]]};
		return neg ? $signed(-mag) : $signed(mag);
	endfunction

endpackage

// File: sv/mrpg_front.sv
// mrpg_front: input side; clamps the index, forms the vertex angle and pushes it to the queue.
// Depends on mrpg_pkg. Holds the credit count that keeps the queue from overflowing.
module mrpg_front #(
	parameter int unsigned QUEUE_DEPTH = mrpg_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [8:0]            point_index,
	input  logic                  outline_mode,
	input  logic [8:0]            step_degrees,
	input  logic                  pop,
	output mrpg_pkg::angle_item_t push
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0] credit_q;
	logic          accept;
	logic [8:0]    idx_sat;

	logic          valid_s1;
	logic [17:0]   ang_raw_s1;
	logic          valid_s2;
	logic [13:0]   part_s2;
	logic          valid_s3;
	logic [8:0]    angle_s3;

	// Partial mod 360: removes multiples of 360*32 and above
	function automatic logic [13:0] reduce_hi(input logic [17:0] v);
		logic [17:0] t;
		t = v;
		for (int j = 9; j >= 5; j--) begin
			if (t >= (18'(mrpg_pkg::ANGLE_MOD) << j)) begin
				t = t - (18'(mrpg_pkg::ANGLE_MOD) << j);
			end
		end
		return t[13:0];
	endfunction

	// Final mod 360 on a value below 360*32
	function automatic logic [8:0] reduce_lo(input logic [13:0] v);
		logic [13:0] t;
		t = v;
		for (int j = 4; j >= 0; j--) begin
			if (t >= (14'(mrpg_pkg::ANGLE_MOD) << j)) begin
				t = t - (14'(mrpg_pkg::ANGLE_MOD) << j);
			end
		end
		return t[8:0];
	endfunction

	// Credits: one per free queue slot not already claimed by an item in flight
	assign in_stall = (credit_q == '0);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CW'(QUEUE_DEPTH);
		end else begin
			case ({accept, pop})
				2'b10:   credit_q <= credit_q - 1'b1;
				2'b01:   credit_q <= credit_q + 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	// Indexes past the curve stick at the last point
	always_comb begin
		if (32'(point_index) >= mrpg_pkg::POINT_COUNT) begin
			idx_sat = mrpg_pkg::IDX_LAST;
		end else begin
			idx_sat = point_index;
		end
	end

	// Valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Angle datapath: raw angle, then mod 360 in two halves
	always_ff @(posedge clk) begin
		if (outline_mode) begin
			ang_raw_s1 <= 18'(idx_sat);
		end else begin
			ang_raw_s1 <= 18'(idx_sat) * 18'(step_degrees);
		end
		part_s2  <= reduce_hi(ang_raw_s1);
		angle_s3 <= reduce_lo(part_s2);
	end

	assign push.valid = valid_s3;
	assign push.angle = angle_s3;

endmodule

// File: sv/mrpg_queue.sv
// mrpg_queue: short first-in first-out queue of angles between front and back.
// Depends on mrpg_pkg. Head entry is visible while the queue is not empty.
module mrpg_queue #(
	parameter int unsigned QUEUE_DEPTH = mrpg_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mrpg_pkg::angle_item_t push,
	input  logic                  pop,
	output mrpg_pkg::angle_item_t head
);

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic [8:0]    mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.angle;
		end
	end

	assign head.valid = (count_q != '0);
	assign head.angle = mem_q[rd_ptr_q];

endmodule

// File: sv/mrpg_back.sv
// mrpg_back: six-stage vertex pipeline; radius sine, cos/sin lookups, products, scaling.
// Depends on mrpg_pkg for the sine table and output format. Stalls stage by stage.
module mrpg_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mrpg_pkg::angle_item_t   head,
	output logic                    pop,
	input  logic [6:0]              harmonic,
	input  logic [8:0]              scale,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [17:0]      x_pos,
	output logic signed [17:0]      y_pos
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	logic [8:0]         angle_s1;
	logic [15:0]        rk_prod_s1;
	logic [8:0]         angle_s2;
	logic [8:0]         cos_ang_s2;
	logic [8:0]         rk_s2;
	logic signed [15:0] r_s3, c_s3, s_s3;
	logic signed [31:0] rc_s4, rs_s4;
	logic               xneg_s5, yneg_s5;
	logic [38:0]        xmag_s5, ymag_s5;
	logic signed [17:0] x_s6, y_s6;

	// mod 360 of harmonic * angle (below 360*128)
	function automatic logic [8:0] reduce_rk(input logic [15:0] v);
		logic [15:0] t;
		t = v;
		for (int j = 6; j >= 0; j--) begin
			if (t >= (16'(mrpg_pkg::ANGLE_MOD) << j)) begin
				t = t - (16'(mrpg_pkg::ANGLE_MOD) << j);
			end
		end
		return t[8:0];
	endfunction

	function automatic logic [29:0] mag30(input logic signed [31:0] p);
		logic [31:0] m;
		m = p[31] ? 32'(-p) : 32'(p);
		return m[29:0];
	endfunction

	// Round half away from zero, then clamp to the 18-bit signed range
	function automatic logic signed [17:0] round_sat(input logic neg, input logic [38:0] m);
		logic [39:0] t;
		t = (40'(m) + mrpg_pkg::ROUND_ADD) >> mrpg_pkg::RND_SHIFT;
		if (neg) begin
			if (t >= mrpg_pkg::OUT_NEG_LIM) begin
				return 18'sh20000;
			end
			return $signed(-t[17:0]);
		end
		if (t > mrpg_pkg::OUT_POS_LIM) begin
			return 18'sh1FFFF;
		end
		return $signed(t[17:0]);
	endfunction

	// Stage enables: a stage loads when empty or when the next one moves on
	assign en_s6 = !valid_s6 || !out_stall;
	assign en_s5 = !valid_s5 || en_s6;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign pop   = head.valid && en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= head.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
		end
	end

	// s1: harmonic product
	always_ff @(posedge clk) begin
		if (en_s1) begin
			angle_s1   <= head.angle;
			rk_prod_s1 <= 16'(harmonic) * 16'(head.angle);
		end
	end

	// s2: radius angle mod 360, cosine angle as angle + 90
	always_ff @(posedge clk) begin
		if (en_s2) begin
			angle_s2 <= angle_s1;
			rk_s2    <= reduce_rk(rk_prod_s1);
			if (angle_s1 >= mrpg_pkg::DEG_270) begin
				cos_ang_s2 <= angle_s1 - mrpg_pkg::DEG_270;
			end else begin
				cos_ang_s2 <= angle_s1 + mrpg_pkg::DEG_90;
			end
		end
	end

	// s3: table lookups
	always_ff @(posedge clk) begin
		if (en_s3) begin
			r_s3 <= mrpg_pkg::sine_q15(rk_s2);
			c_s3 <= mrpg_pkg::sine_q15(cos_ang_s2);
			s_s3 <= mrpg_pkg::sine_q15(angle_s2);
		end
	end

	// s4: Q2.30 products
	always_ff @(posedge clk) begin
		if (en_s4) begin
			rc_s4 <= r_s3 * c_s3;
			rs_s4 <= r_s3 * s_s3;
		end
	end

	// s5: magnitude times scale
	always_ff @(posedge clk) begin
		if (en_s5) begin
			xneg_s5 <= rc_s4[31];
			yneg_s5 <= rs_s4[31];
			xmag_s5 <= 39'(mag30(rc_s4)) * 39'(scale);
			ymag_s5 <= 39'(mag30(rs_s4)) * 39'(scale);
		end
	end

	// s6: output register
	always_ff @(posedge clk) begin
		if (en_s6) begin
			x_s6 <= round_sat(xneg_s5, xmag_s5);
			y_s6 <= round_sat(yneg_s5, ymag_s5);
		end
	end

	assign out_valid = valid_s6;
	assign x_pos     = x_s6;
	assign y_pos     = y_s6;

endmodule

// File: sv/maurer_rose_point_generator_core.sv
// Maurer rose point generator: top level with configuration registers.
// Depends on mrpg_pkg, mrpg_front, mrpg_queue and mrpg_back.
//
// Usage:
//   Input channel (in_valid / in_stall, point_index, outline_mode): one
//   transaction per vertex. Output channel (out_valid / out_stall, x_pos,
//   y_pos): one transaction per input, in order, signed with 8 fraction bits.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data):
//   0 harmonic, 1 step_degrees, 2 scale; other indexes are ignored.
//   cfg_ready is always high; write only while no vertex is in flight.
// Timing:
//   Throughput is one vertex per clock while out_stall is low. From input
//   transaction to out_valid, with an empty queue, a vertex passes three front stages for the
//   angle multiply and mod 360, one queue slot, six back stages (harmonic
//   multiply, mod 360, sine table, products, scaling, rounding).
//   QUEUE_DEPTH credits bound the items between input and back pipeline;
//   at least 5 keeps the rate at one per clock.
// Reset and stall:
//   Reset empties all stages and the queue and loads harmonic 6, step 71,
//   scale 200. When out_stall is high the output holds; the back pipeline
//   fills, then the queue, and in_stall rises once the credits run out.
module maurer_rose_point_generator_core #(
	parameter int unsigned QUEUE_DEPTH = mrpg_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [8:0]         point_index,
	input  logic               outline_mode,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [17:0] x_pos,
	output logic signed [17:0] y_pos,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data
);

	logic [6:0] harmonic_q;
	logic [8:0] step_q;
	logic [8:0] scale_q;

	mrpg_pkg::angle_item_t push;
	mrpg_pkg::angle_item_t head;
	logic                  pop;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			harmonic_q <= mrpg_pkg::HARMONIC_RST;
			step_q     <= mrpg_pkg::STEP_RST;
			scale_q    <= mrpg_pkg::SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mrpg_pkg::REG_HARMONIC: harmonic_q <= cfg_data[6:0];
				mrpg_pkg::REG_STEP:     step_q     <= cfg_data;
				mrpg_pkg::REG_SCALE:    scale_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	mrpg_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.point_index  (point_index),
		.outline_mode (outline_mode),
		.step_degrees (step_q),
		.pop          (pop),
		.push         (push)
	);

	mrpg_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head)
	);

	mrpg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.harmonic  (harmonic_q),
		.scale     (scale_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.x_pos     (x_pos),
		.y_pos     (y_pos)
	);

endmodule

// File: sv/mrpg_checker.sv
// mrpg_checker: port-level assertions for the Maurer rose point generator, and its bind.
// Depends on mrpg_pkg through its own QUEUE_DEPTH parameter default.
module mrpg_checker #(
	parameter int unsigned QUEUE_DEPTH = mrpg_pkg::QUEUE_DEPTH
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [17:0] x_pos,
	input logic signed [17:0] y_pos
);

	localparam int unsigned BACK_STAGES = 6;
	localparam logic [7:0]  OUTSTANDING_MAX = 8'(QUEUE_DEPTH + BACK_STAGES);

	logic       in_acc;
	logic       out_acc;
	logic [7:0] outstanding_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Transactions taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   outstanding_q <= outstanding_q + 1'b1;
				2'b01:   outstanding_q <= outstanding_q - 1'b1;
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(x_pos) && $stable(y_pos))
		else $error("output changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> outstanding_q != 8'd0)
		else $error("result delivered with nothing in flight");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= OUTSTANDING_MAX)
		else $error("more items in flight than the credits allow");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q == 8'd0 |-> !in_stall)
		else $error("input stalled while the block is empty");

endmodule

bind maurer_rose_point_generator_core mrpg_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_mrpg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.x_pos     (x_pos),
	.y_pos     (y_pos)
);

// File: dv/maurer_rose_point_generator_core_tb.sv
// Self-checking testbench for maurer_rose_point_generator_core: a built-in vertex predictor,
// directed corner cases, then randomized config phases with random input gaps and output stalls.
// Depends on mrpg_pkg and the RTL of the core only.
`timescale 1ns / 100ps

module maurer_rose_point_generator_core_tb;

	localparam logic [1:0] REG_UNMAPPED = 2'd3;
	localparam int         QUIET_LIMIT  = 2000;
	localparam int         SETTLE_CYCLES = 14;

	typedef struct {
		logic [8:0]        idx;
		logic              outline;
		logic signed [17:0] x;
		logic signed [17:0] y;
	} vertex_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [8:0]        point_index  = '0;
	logic              outline_mode = 1'b0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic signed [17:0] x_pos;
	logic signed [17:0] y_pos;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index    = '0;
	logic [8:0]        cfg_data     = '0;

	// Predictor copy of the configuration
	logic [6:0] rose_harmonic;
	logic [8:0] rose_step;
	logic [8:0] rose_scale;

	logic [14:0] quarter_wave [0:90];
	vertex_t     pending_vertices [$];
	int          error_count = 0;
	int          quiet_cycles = 0;
	bit          idle_en = 1'b1;
	int          stall_left = 0;

	maurer_rose_point_generator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.point_index  (point_index),
		.outline_mode (outline_mode),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Quarter-wave sine, Q1.15, from a 9-term fixed-point Taylor series
	function automatic logic [14:0] taylor_sine(input int unsigned deg);
		logic [63:0] rad;
		logic [63:0] rad_sq;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] rounded;
		rad    = 64'(deg) * 64'd18740330;
		rad_sq = (rad * rad) >> 30;
		term   = rad;
		acc    = rad;
		for (int n = 1; n <= 8; n++) begin
			term = ((term * rad_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		rounded = (acc + 64'd16384) >> 15;
		if (rounded > 64'd32767) begin
			rounded = 64'd32767;
		end
		return rounded[14:0];
	endfunction

	// Full-circle sine in integer degrees
	function automatic longint sine_of(input int unsigned deg);
		int unsigned d;
		d = deg % 360;
		if (d <= 90) begin
			return longint'(quarter_wave[d]);
		end else if (d <= 180) begin
			return longint'(quarter_wave[180 - d]);
		end else if (d <= 270) begin
			return -longint'(quarter_wave[d - 180]);
		end
		return -longint'(quarter_wave[360 - d]);
	endfunction

	// Q2.30 product times scale, rounded half away from zero, saturated to 18 bits
	function automatic logic signed [17:0] scale_coord(input longint prod);
		logic         neg;
		longint unsigned mag;
		longint       v;
		neg = prod < 0;
		mag = neg ? longint'(-prod) : longint'(prod);
		mag = mag * longint'(rose_scale);
		mag = (mag + (64'd1 << (29 - mrpg_pkg::OUT_FRAC_BITS)))
			>> (30 - mrpg_pkg::OUT_FRAC_BITS);
		if (mag > (64'd1 << 20)) begin
			mag = 64'd1 << 20;
		end
		v = neg ? -longint'(mag) : longint'(mag);
		if (v > 131071) begin
			v = 131071;
		end
		if (v < -131072) begin
			v = -131072;
		end
		return v[17:0];
	endfunction

	function automatic vertex_t predict_vertex(input logic [8:0] idx, input logic outline);
		vertex_t     v;
		int unsigned pt;
		int unsigned k;
		int unsigned rk;
		longint      r;
		pt = (idx >= mrpg_pkg::POINT_COUNT) ? mrpg_pkg::POINT_COUNT - 1 : idx;
		k  = outline ? pt % 360 : (pt * rose_step) % 360;
		rk = (rose_harmonic * k) % 360;
		r  = sine_of(rk);
		v.idx     = idx;
		v.outline = outline;
		v.x       = scale_coord(r * sine_of(k + 90));
		v.y       = scale_coord(r * sine_of(k));
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	// Send one vertex request; entered and left just after a rising edge
	task automatic send_point(input logic [8:0] idx, input logic outline);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		point_index  <= idx;
		outline_mode <= outline;
		do @(posedge clk); while (in_stall);
		pending_vertices.push_back(predict_vertex(idx, outline));
	endtask

	// Stop sending and wait until every vertex has come back, then let the pipe settle
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the write channel is then left idle before the task returns
	task automatic write_reg(input logic [1:0] index, input logic [8:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			mrpg_pkg::REG_HARMONIC: rose_harmonic = data[6:0];
			mrpg_pkg::REG_STEP:     rose_step     = data;
			mrpg_pkg::REG_SCALE:    rose_scale    = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [8:0] harm, input logic [8:0] stp,
			input logic [8:0] scl);
		drain_pipe();
		write_reg(mrpg_pkg::REG_HARMONIC, harm);
		write_reg(mrpg_pkg::REG_STEP, stp);
		write_reg(mrpg_pkg::REG_SCALE, scl);
	endtask

	// Reset values, both modes, index extremes and the saturated index
	task automatic test_reset_config();
		send_point(9'd0, 1'b0);
		send_point(9'd1, 1'b0);
		send_point(9'd360, 1'b0);
		send_point(9'd361, 1'b0);
		send_point(9'h1FF, 1'b0);
		send_point(9'd90, 1'b1);
		send_point(9'd180, 1'b1);
		send_point(9'd270, 1'b1);
		send_point(9'd359, 1'b1);
		send_point(9'h1FF, 1'b1);
		send_point(9'h100, 1'b1);
		send_point(9'h0FF, 1'b0);
	endtask

	// Zero harmonic gives the origin; out-of-range step and harmonic wrap; scale extremes
	task automatic test_config_corners();
		set_config(9'd0, 9'd71, 9'd200);
		send_point(9'd45, 1'b0);
		send_point(9'd45, 1'b1);
		set_config(9'h1FF, 9'h1FF, 9'd500);
		send_point(9'd7, 1'b0);
		send_point(9'd300, 1'b1);
		set_config(9'd100, 9'd360, 9'd50);
		send_point(9'd13, 1'b0);
		send_point(9'd13, 1'b1);
		set_config(9'd1, 9'd0, 9'h1FF);
		send_point(9'd45, 1'b1);
		send_point(9'd135, 1'b1);
		set_config(9'd2, 9'd1, 9'd0);
		send_point(9'd30, 1'b1);
		// Write to an unmapped index must leave the settings alone
		drain_pipe();
		write_reg(REG_UNMAPPED, 9'd3);
		send_point(9'd30, 1'b0);
	endtask

	task automatic test_random_phases();
		logic [8:0] harm;
		logic [8:0] stp;
		logic [8:0] scl;
		logic [8:0] idx;
		for (int p = 0; p < 6; p++) begin
			case ($urandom_range(0, 7))
				0: harm = 9'd0;
				1: harm = 9'd100;
				2: harm = 9'($urandom_range(0, 511));
				default: harm = 9'($urandom_range(1, 99));
			endcase
			case ($urandom_range(0, 7))
				0: stp = 9'd0;
				1: stp = 9'd360;
				2: stp = 9'($urandom_range(361, 511));
				default: stp = 9'($urandom_range(1, 359));
			endcase
			case ($urandom_range(0, 7))
				0: scl = 9'd50;
				1: scl = 9'd500;
				2: scl = 9'($urandom_range(0, 511));
				default: scl = 9'($urandom_range(50, 500));
			endcase
			set_config(harm, stp, scl);
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_UNMAPPED, 9'($urandom_range(0, 511)));
			end
			// Alternate idle and busy stretches; the last phase runs flat out
			idle_en = (p < 5) && (p % 2 == 0);
			for (int i = 0; i < 125; i++) begin
				if ($urandom_range(0, 7) == 0) begin
					idx = 9'($urandom_range(361, 511));
				end else begin
					idx = 9'($urandom_range(0, 360));
				end
				send_point(idx, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Check each output transaction against the oldest prediction
	always @(posedge clk) begin
		vertex_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_vertices.size() == 0) begin
				report_mismatch($sformatf("unexpected vertex x=%0d y=%0d", x_pos, y_pos));
			end else begin
				want = pending_vertices.pop_front();
				if (x_pos !== want.x) begin
					report_mismatch($sformatf("x_pos idx=%0d outline=%0b: expected %0d got %0d",
						want.idx, want.outline, want.x, x_pos));
				end
				if (y_pos !== want.y) begin
					report_mismatch($sformatf("y_pos idx=%0d outline=%0b: expected %0d got %0d",
						want.idx, want.outline, want.y, y_pos));
				end
			end
		end
	end

	// Output back-pressure in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(1, 7) - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("maurer_rose_point_generator_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		for (int d = 0; d <= 90; d++) begin
			quarter_wave[d] = taylor_sine(d);
		end
		rose_harmonic = mrpg_pkg::HARMONIC_RST;
		rose_step     = mrpg_pkg::STEP_RST;
		rose_scale    = mrpg_pkg::SCALE_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_config_corners();
		test_random_phases();
		drain_pipe();
		if (error_count == 0) begin
			$display("maurer_rose_point_generator_core regression: pass");
		end else begin
			$display("maurer_rose_point_generator_core regression: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/mrpg_pkg.sv
sv/mrpg_front.sv
sv/mrpg_queue.sv
sv/mrpg_back.sv
sv/maurer_rose_point_generator_core.sv
sv/mrpg_checker.sv
dv/maurer_rose_point_generator_core_tb.sv
